// ===== design/gtl_pkg.sv =====
// shared types and constants for the grammar token lexer
package gtl_pkg;

    typedef enum logic [2:0] {
        K_END   = 3'd0,
        K_BAR   = 3'd1,
        K_STAR  = 3'd2,
        K_COLON = 3'd3,
        K_EQUAL = 3'd4,
        K_DOT   = 3'd5,
        K_IDENT = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_FULL  = 2'd1,
        E_QUOTE = 2'd2,
        E_CHAR  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        M_IDLE   = 2'd0,
        M_WORD   = 2'd1,
        M_QUOTED = 2'd2,
        M_HALTED = 2'd3
    } t_mode;

    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [19:0] LINE_MAX = 20'hFFFFF;

    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = 2;
    localparam int IQ_CNT_W = 3;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CNT_W = 3;

    // one classified input beat
    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
        logic       is_space;
        logic       is_nl;
        logic       is_letter;
        logic       is_digit;
        logic       is_quote;
        logic       is_punct;
        t_kind      punct_kind;
    } t_item;

    // one token
    typedef struct packed {
        t_kind       kind;
        logic [11:0] word_start;
        logic [19:0] line;
        t_err        err;
        logic [7:0]  bad_char;
        logic        last;
    } t_res;

endpackage

// ===== design/gtl_front.sv =====
// input stage: takes character beats and classifies them
module gtl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_ch,
    input  logic          i_at_end,
    output logic          o_valid,
    input  logic          i_ready,
    output gtl_pkg::t_item o_item
);

    logic           r_vld;
    gtl_pkg::t_item r_item;
    gtl_pkg::t_item n_item;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_item            = '0;
        n_item.ch         = i_ch;
        n_item.at_end     = i_at_end;
        n_item.is_space   = (i_ch == gtl_pkg::CH_SPACE) ||
                            ((i_ch >= gtl_pkg::CH_TAB) && (i_ch <= gtl_pkg::CH_CR));
        n_item.is_nl      = (i_ch == gtl_pkg::CH_NL);
        n_item.is_letter  = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ||
                            ((i_ch >= 8'h41) && (i_ch <= 8'h5A)) ||
                            (i_ch == gtl_pkg::CH_UNDER);
        n_item.is_digit   = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        n_item.is_quote   = (i_ch == gtl_pkg::CH_QUOTE);
        n_item.is_punct   = 1'b1;
        n_item.punct_kind = gtl_pkg::K_END;
        case (i_ch)
            gtl_pkg::CH_BAR:   n_item.punct_kind = gtl_pkg::K_BAR;
            gtl_pkg::CH_STAR:  n_item.punct_kind = gtl_pkg::K_STAR;
            gtl_pkg::CH_COLON: n_item.punct_kind = gtl_pkg::K_COLON;
            gtl_pkg::CH_EQUAL: n_item.punct_kind = gtl_pkg::K_EQUAL;
            gtl_pkg::CH_DOT:   n_item.punct_kind = gtl_pkg::K_DOT;
            default:           n_item.is_punct   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/gtl_item_q.sv =====
// short queue of classified beats between front and back
module gtl_item_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  gtl_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output gtl_pkg::t_item o_item
);

    gtl_pkg::t_item               r_mem [gtl_pkg::IQ_DEPTH];
    logic [gtl_pkg::IQ_AW-1:0]    r_wp;
    logic [gtl_pkg::IQ_AW-1:0]    r_rp;
    logic [gtl_pkg::IQ_CNT_W-1:0] r_cnt;
    logic                         push_ok;
    logic                         pop_ok;

    assign o_ready = (r_cnt != gtl_pkg::IQ_CNT_W'(gtl_pkg::IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + gtl_pkg::IQ_CNT_W'(push_ok) - gtl_pkg::IQ_CNT_W'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== design/gtl_back.sv =====
// lexer state, character store and token queue
module gtl_back #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  gtl_pkg::t_item i_item,
    output logic           o_item_pop,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output gtl_pkg::t_res  o_res
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);

    logic [7:0]                   r_store [STORE_DEPTH];
    gtl_pkg::t_mode               r_mode;
    gtl_pkg::t_mode               n_mode;
    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            n_fill;
    logic [ADDR_W-1:0]            r_wb;
    logic [ADDR_W-1:0]            n_wb;
    logic [19:0]                  r_line;
    logic [19:0]                  n_line;

    gtl_pkg::t_res                r_oq [gtl_pkg::OQ_DEPTH];
    logic [gtl_pkg::OQ_AW-1:0]    r_wp;
    logic [gtl_pkg::OQ_AW-1:0]    r_rp;
    logic [gtl_pkg::OQ_CNT_W-1:0] r_cnt;
    logic [gtl_pkg::OQ_CNT_W-1:0] occ;

    logic                         pop;
    logic                         take;
    logic                         full;
    logic                         nl_eff;
    logic [19:0]                  line_inc;
    logic [ADDR_W+11:0]           wb_ext;

    logic                         we;
    logic [ADDR_W-1:0]            waddr;
    logic [7:0]                   wdata;

    logic                         do_idle;
    logic [FILL_W-1:0]            idle_fill;
    logic [1:0]                   nres;
    gtl_pkg::t_res                res0;
    gtl_pkg::t_res                res1;
    gtl_pkg::t_res                b_res;
    logic                         b_emit;

    function automatic gtl_pkg::t_res mk_res(input gtl_pkg::t_kind kind,
                                             input logic [11:0]    ws,
                                             input logic [19:0]    line,
                                             input gtl_pkg::t_err  err,
                                             input logic [7:0]     bad);
        gtl_pkg::t_res r;
        r.kind       = kind;
        r.word_start = ws;
        r.line       = line;
        r.err        = err;
        r.bad_char   = bad;
        r.last       = 1'b0;
        return r;
    endfunction

    assign pop         = o_res_valid && i_res_ready;
    assign o_res_valid = (r_cnt != '0);
    assign o_res       = r_oq[r_rp];
    assign occ         = r_cnt - gtl_pkg::OQ_CNT_W'(pop);
    // room for a two-token step
    assign take        = i_item_valid &&
                         (occ <= gtl_pkg::OQ_CNT_W'(gtl_pkg::OQ_DEPTH - 2));
    assign o_item_pop  = take;

    assign full     = (r_fill == FILL_W'(STORE_DEPTH));
    assign nl_eff   = i_item.is_nl && !i_item.at_end;
    assign line_inc = (nl_eff && (r_line != gtl_pkg::LINE_MAX)) ? r_line + 20'd1 : r_line;
    assign wb_ext   = (ADDR_W + 12)'(r_wb);

    always_comb begin
        n_mode    = r_mode;
        n_fill    = r_fill;
        n_wb      = r_wb;
        n_line    = r_line;
        we        = 1'b0;
        waddr     = r_fill[ADDR_W-1:0];
        wdata     = i_item.ch;
        do_idle   = 1'b0;
        idle_fill = r_fill;
        nres      = 2'd0;
        res0      = mk_res(gtl_pkg::K_END, 12'd0, r_line, gtl_pkg::E_NONE, 8'd0);
        res1      = res0;
        b_res     = res0;
        b_emit    = 1'b0;

        if (take && (r_mode != gtl_pkg::M_HALTED)) begin
            n_line = line_inc;
            // first part: word and quoted string handling
            case (r_mode)
                gtl_pkg::M_IDLE: begin
                    do_idle = 1'b1;
                end
                gtl_pkg::M_WORD: begin
                    if (!i_item.at_end && (i_item.is_letter || i_item.is_digit)) begin
                        if (full) begin
                            res0   = mk_res(gtl_pkg::K_END, 12'd0, r_line,
                                            gtl_pkg::E_FULL, 8'd0);
                            nres   = 2'd1;
                            n_mode = gtl_pkg::M_HALTED;
                        end else begin
                            we     = 1'b1;
                            n_fill = r_fill + 1'b1;
                        end
                    end else if (full) begin
                        res0   = mk_res(gtl_pkg::K_END, 12'd0, r_line,
                                        gtl_pkg::E_FULL, 8'd0);
                        nres   = 2'd1;
                        n_mode = gtl_pkg::M_HALTED;
                    end else begin
                        we        = 1'b1;
                        wdata     = 8'd0;
                        n_fill    = r_fill + 1'b1;
                        res0      = mk_res(gtl_pkg::K_IDENT, wb_ext[11:0], r_line,
                                           gtl_pkg::E_NONE, 8'd0);
                        nres      = 2'd1;
                        n_mode    = gtl_pkg::M_IDLE;
                        do_idle   = 1'b1;
                        idle_fill = r_fill + 1'b1;
                    end
                end
                gtl_pkg::M_QUOTED: begin
                    if (i_item.at_end) begin
                        res0   = mk_res(gtl_pkg::K_END, 12'd0, r_line,
                                        gtl_pkg::E_QUOTE, 8'd0);
                        nres   = 2'd1;
                        n_mode = gtl_pkg::M_HALTED;
                    end else if (i_item.is_quote) begin
                        if (full) begin
                            res0   = mk_res(gtl_pkg::K_END, 12'd0, r_line,
                                            gtl_pkg::E_FULL, 8'd0);
                            nres   = 2'd1;
                            n_mode = gtl_pkg::M_HALTED;
                        end else begin
                            we     = 1'b1;
                            wdata  = 8'd0;
                            n_fill = r_fill + 1'b1;
                            res0   = mk_res(gtl_pkg::K_IDENT, wb_ext[11:0], r_line,
                                            gtl_pkg::E_NONE, 8'd0);
                            nres   = 2'd1;
                            n_mode = gtl_pkg::M_IDLE;
                        end
                    end else if (full) begin
                        // newline already counted for this error
                        res0   = mk_res(gtl_pkg::K_END, 12'd0, line_inc,
                                        gtl_pkg::E_FULL, 8'd0);
                        nres   = 2'd1;
                        n_mode = gtl_pkg::M_HALTED;
                    end else begin
                        we     = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase

            // second part: a character seen in idle mode, or the one that ended a word
            if (do_idle) begin
                if (i_item.at_end) begin
                    b_res  = mk_res(gtl_pkg::K_END, 12'd0, r_line, gtl_pkg::E_NONE, 8'd0);
                    b_emit = 1'b1;
                    n_mode = gtl_pkg::M_HALTED;
                end else if (i_item.is_space) begin
                    b_emit = 1'b0;
                end else if (i_item.is_punct) begin
                    b_res  = mk_res(i_item.punct_kind, 12'd0, r_line,
                                    gtl_pkg::E_NONE, 8'd0);
                    b_emit = 1'b1;
                end else if (i_item.is_letter) begin
                    n_wb = idle_fill[ADDR_W-1:0];
                    if (idle_fill == FILL_W'(STORE_DEPTH)) begin
                        b_res  = mk_res(gtl_pkg::K_END, 12'd0, r_line,
                                        gtl_pkg::E_FULL, 8'd0);
                        b_emit = 1'b1;
                        n_mode = gtl_pkg::M_HALTED;
                    end else begin
                        we     = 1'b1;
                        waddr  = idle_fill[ADDR_W-1:0];
                        wdata  = i_item.ch;
                        n_fill = idle_fill + 1'b1;
                        n_mode = gtl_pkg::M_WORD;
                    end
                end else if (i_item.is_quote) begin
                    n_wb   = idle_fill[ADDR_W-1:0];
                    n_mode = gtl_pkg::M_QUOTED;
                end else begin
                    b_res  = mk_res(gtl_pkg::K_END, 12'd0, r_line,
                                    gtl_pkg::E_CHAR, i_item.ch);
                    b_emit = 1'b1;
                    n_mode = gtl_pkg::M_HALTED;
                end
                if (b_emit) begin
                    if (nres == 2'd0) begin
                        res0 = b_res;
                        nres = 2'd1;
                    end else begin
                        res1 = b_res;
                        nres = 2'd2;
                    end
                end
            end

            if (nres == 2'd1) begin
                res0.last = 1'b1;
            end else if (nres == 2'd2) begin
                res1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gtl_pkg::M_IDLE;
            r_fill <= '0;
            r_wb   <= '0;
            r_line <= 20'd1;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_mode <= n_mode;
            r_fill <= n_fill;
            r_wb   <= n_wb;
            r_line <= n_line;
            r_wp   <= r_wp + gtl_pkg::OQ_AW'(nres);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt  <= r_cnt + gtl_pkg::OQ_CNT_W'(nres) - gtl_pkg::OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (nres != 2'd0) begin
            r_oq[r_wp] <= res0;
        end
        if (nres == 2'd2) begin
            r_oq[r_wp + 1'b1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
    end

endmodule

// ===== design/grammar_token_lexer.sv =====
// grammar token lexer top level: classifier, beat queue and token engine
// path: a character beat passes the front register, the beat queue and the token queue
// throughput: one character beat per cycle when the token queue has room for two tokens,
//   set by the single store write port and the one-token-per-cycle output; a beat that
//   ends an identifier and makes a second token costs two output beats
// reset: synchronous active low; mode idle, fill 0, line 1, queues empty;
//   the character store is not cleared
module grammar_token_lexer #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side: one character beat
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,   // at_end: end of input mark
    // output side: one token beat
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [11:0] word_start, [31:12] line,
                                          // [33:32] error, [41:34] bad_char
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast    // last token of the input beat
);

    gtl_pkg::t_item front_item;
    gtl_pkg::t_item q_item;
    gtl_pkg::t_res  res;
    logic           front_valid;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;

    // front: registers and classifies each character beat
    gtl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_ch     (i_s_axis_tdata),
        .i_at_end (i_s_axis_tlast),
        .o_valid  (front_valid),
        .i_ready  (q_ready),
        .o_item   (front_item)
    );

    // decoupling queue so front and back stall independently
    gtl_item_q u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (q_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // back: lexer state, store writes and the token queue
    gtl_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res)
    );

    // token fields packed lowest first, padded to whole bytes
    assign o_m_axis_tdata = {6'd0, res.bad_char, res.err, res.line, res.word_start};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

// ===== verif/gtl_token_checker.sv =====
// token checker for the grammar token lexer: predicts tokens from character beats and compares
module gtl_token_checker #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,   // at_end
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [47:0] i_m_axis_tdata,   // [11:0] word_start, [31:12] line,
                                          // [33:32] error, [41:34] bad_char
    input  logic [2:0]  i_m_axis_tuser,   // [2:0] kind
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_store_used
);
    import gtl_pkg::*;

    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7A;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5A;
    localparam logic [7:0] CH_DIG0 = 8'h30;
    localparam logic [7:0] CH_DIG9 = 8'h39;

    t_mode       lx_mode;
    int          lx_fill;
    logic [11:0] lx_word_begin;
    logic [19:0] lx_line;
    t_res        beat_tokens [2];
    int          beat_count;
    t_res        pending_tokens [$];
    int          mismatches;

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_head(logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)
            || c == CH_UNDER;
    endfunction

    function automatic logic is_tail(logic [7:0] c);
        return is_head(c) || (c >= CH_DIG0 && c <= CH_DIG9);
    endfunction

    function automatic void count_newline(logic [7:0] c);
        if (c == CH_NL && lx_line != LINE_MAX) begin
            lx_line = lx_line + 20'd1;
        end
    endfunction

    // one store write; refused once the store is full
    function automatic logic store_byte();
        if (lx_fill >= STORE_DEPTH) begin
            return 1'b0;
        end
        lx_fill = lx_fill + 1;
        return 1'b1;
    endfunction

    function automatic void make_token(t_kind kind, logic [11:0] start, t_err err,
                                       logic [7:0] bad);
        t_res tok;
        tok.kind       = kind;
        tok.word_start = start;
        tok.line       = lx_line;
        tok.err        = err;
        tok.bad_char   = bad;
        tok.last       = 1'b0;
        beat_tokens[beat_count] = tok;
        beat_count = beat_count + 1;
        if (err != E_NONE || kind == K_END) begin
            lx_mode = M_HALTED;
        end
    endfunction

    function automatic void lex_idle(logic [7:0] c);
        if (is_blank(c)) begin
            count_newline(c);
        end else begin
            case (c)
                CH_BAR:   make_token(K_BAR, '0, E_NONE, '0);
                CH_STAR:  make_token(K_STAR, '0, E_NONE, '0);
                CH_COLON: make_token(K_COLON, '0, E_NONE, '0);
                CH_EQUAL: make_token(K_EQUAL, '0, E_NONE, '0);
                CH_DOT:   make_token(K_DOT, '0, E_NONE, '0);
                default: begin
                    if (is_head(c)) begin
                        lx_word_begin = 12'(lx_fill);
                        if (store_byte()) begin
                            lx_mode = M_WORD;
                        end else begin
                            make_token(K_END, '0, E_FULL, '0);
                        end
                    end else if (c == CH_QUOTE) begin
                        lx_word_begin = 12'(lx_fill);
                        lx_mode = M_QUOTED;
                    end else begin
                        make_token(K_END, '0, E_CHAR, c);
                    end
                end
            endcase
        end
    endfunction

    // terminator write, then the word token
    function automatic void close_word();
        if (store_byte()) begin
            lx_mode = M_IDLE;
            make_token(K_IDENT, lx_word_begin, E_NONE, '0);
        end else begin
            make_token(K_END, '0, E_FULL, '0);
        end
    endfunction

    function automatic void lex_beat(logic [7:0] c, logic at_end);
        beat_count = 0;
        case (lx_mode)
            M_IDLE: begin
                if (at_end) begin
                    make_token(K_END, '0, E_NONE, '0);
                end else begin
                    lex_idle(c);
                end
            end
            M_WORD: begin
                if (!at_end && is_tail(c)) begin
                    if (!store_byte()) begin
                        make_token(K_END, '0, E_FULL, '0);
                    end
                end else begin
                    close_word();
                    // the character that ended the word is classified too
                    if (lx_mode == M_IDLE) begin
                        if (at_end) begin
                            make_token(K_END, '0, E_NONE, '0);
                        end else begin
                            lex_idle(c);
                        end
                    end
                end
            end
            M_QUOTED: begin
                if (at_end) begin
                    make_token(K_END, '0, E_QUOTE, '0);
                end else if (c == CH_QUOTE) begin
                    close_word();
                end else begin
                    count_newline(c);
                    if (!store_byte()) begin
                        make_token(K_END, '0, E_FULL, '0);
                    end
                end
            end
            default: ;
        endcase
        if (beat_count > 0) begin
            beat_tokens[beat_count - 1].last = 1'b1;
        end
        for (int i = 0; i < beat_count; i++) begin
            pending_tokens.push_back(beat_tokens[i]);
        end
    endfunction

    task automatic cmp_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    task automatic check_token(input logic [47:0] data, input logic [2:0] kind,
                               input logic last);
        t_res want;
        if (pending_tokens.size() == 0) begin
            $error("token beat with nothing expected: kind %0d line %0d", kind, data[31:12]);
            mismatches = mismatches + 1;
        end else begin
            want = pending_tokens.pop_front();
            cmp_field("kind", want.kind, kind);
            cmp_field("word_start", want.word_start, data[11:0]);
            cmp_field("line", want.line, data[31:12]);
            cmp_field("error", want.err, data[33:32]);
            cmp_field("bad_char", want.bad_char, data[41:34]);
            cmp_field("last", want.last, last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lx_mode       = M_IDLE;
            lx_fill       = 0;
            lx_word_begin = '0;
            lx_line       = 20'd1;
            mismatches    = 0;
            pending_tokens.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                lex_beat(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_token(i_m_axis_tdata, i_m_axis_tuser, i_m_axis_tlast);
            end
        end
        o_fail_count = mismatches;
        o_pending    = pending_tokens.size();
        o_store_used = lx_fill;
    end

endmodule

// ===== verif/testbench.sv =====
// testbench top for the grammar token lexer: clock, reset, character stimulus and verdict
module testbench;
    import gtl_pkg::*;

    localparam int STORE_DEPTH  = 4096;
    localparam int RANDOM_BEATS = 700;
    localparam int AFTER_HALT   = 8;
    localparam int STALL_LIMIT  = 2000;      // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 16;

    // how the run is brought to its single halt, picked once per seed
    typedef enum int {
        END_IDLE,
        END_IN_WORD,
        END_IN_QUOTE,
        STRAY_CHAR,
        FULL_ON_TERM,
        FULL_IN_QUOTE
    } t_ending;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'h00;   // [7:0] ch
    logic        i_s_axis_tlast  = 1'b0;    // at_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;            // [11:0] word_start, [31:12] line,
                                            // [33:32] error, [41:34] bad_char
    logic [2:0]  o_m_axis_tuser;            // [2:0] kind
    logic        o_m_axis_tlast;

    int fail_count;
    int pending;
    int store_used;
    int beats_sent    = 0;
    int send_idle_pct = 29;
    int take_idle_pct = 49;

    grammar_token_lexer #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    gtl_token_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tuser (o_m_axis_tuser),
        .i_m_axis_tlast (o_m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_store_used   (store_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // token side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
    end

    // letters and underscore start a word; digits only continue one
    function automatic logic [7:0] word_char(input logic head_only);
        int r;
        r = head_only ? $urandom_range(52) : $urandom_range(62);
        if (r < 26) begin
            return 8'(8'h61 + r);          // a to z
        end
        if (r < 52) begin
            return 8'(8'h41 + r - 26);     // A to Z
        end
        if (r == 52) begin
            return CH_UNDER;
        end
        return 8'(8'h30 + r - 53);         // 0 to 9
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(4))
            0:       return CH_BAR;
            1:       return CH_STAR;
            2:       return CH_COLON;
            3:       return CH_EQUAL;
            default: return CH_DOT;
        endcase
    endfunction

    // newline weighted up so the line counter moves
    function automatic logic [7:0] blank_char();
        case ($urandom_range(6))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return 8'h0B;          // vertical tab
            3:       return 8'h0C;          // form feed
            4:       return CH_CR;
            default: return CH_NL;
        endcase
    endfunction

    // any byte but the closing quote, newline now and then
    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        if ($urandom_range(7) == 0) begin
            return CH_NL;
        end
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        return c;
    endfunction

    // a byte that starts nothing in idle mode, digits and high bytes included
    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_QUOTE
               || c == CH_UNDER || c == CH_BAR || c == CH_STAR || c == CH_COLON
               || c == CH_EQUAL || c == CH_DOT
               || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A));
        return c;
    endfunction

    // one character beat; random sender gaps come before the beat is offered
    task automatic send_char(input logic [7:0] c, input logic end_mark);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= end_mark;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        beats_sent = beats_sent + 1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0);
        end
    endtask

    task automatic send_quoted(input int n);
        send_char(CH_QUOTE, 1'b0);
        repeat (n) begin
            send_char(quoted_char(), 1'b0);
        end
        send_char(CH_QUOTE, 1'b0);
    endtask

    // one well-formed lexeme; a word runs straight into whatever follows
    task automatic random_piece();
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            send_char(word_char(1'b1), 1'b0);
            repeat ($urandom_range(7)) begin
                send_char(word_char(1'b0), 1'b0);
            end
        end else if (r < 60) begin
            send_char(punct_char(), 1'b0);
        end else if (r < 75) begin
            repeat (1 + $urandom_range(2)) begin
                send_char(blank_char(), 1'b0);
            end
        end else begin
            send_quoted($urandom_range(12));
        end
    endtask

    // the block halts for good after its first end or error token, and reset
    // comes only once, so every run closes on exactly one halting case
    initial begin : stimulus
        int      room;
        t_ending ending;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening: every punctuation mark, every blank, word edges,
        // a word closed by punctuation, by newline and by a quote, then a
        // string holding zero, top-bit and newline bytes, then an empty string
        send_text("|*:=. \t\013\014\015_Zaz09A|q\nw\"");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(8'h80, 1'b0);
        send_text("\"\"\"");

        // random lexemes; idling swaps sides a third of the way in, then stops
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent >= 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else if (beats_sent >= RANDOM_BEATS / 3) begin
                send_idle_pct = 49;
                take_idle_pct = 29;
            end
            random_piece();
        end

        // newlines around a word and inside a string
        send_text("|\nsat\n\"\n\"*");

        // settle the store count before sizing an overflow
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        room = STORE_DEPTH - store_used;

        ending = t_ending'($urandom_range(5));
        case (ending)
            END_IDLE: begin
                send_char(8'($urandom_range(255)), 1'b1);
            end
            END_IN_WORD: begin
                send_char(word_char(1'b1), 1'b0);
                send_char(word_char(1'b0), 1'b0);
                send_char(8'($urandom_range(255)), 1'b1);
            end
            END_IN_QUOTE: begin
                send_char(CH_QUOTE, 1'b0);
                send_char(quoted_char(), 1'b0);
                send_char(8'($urandom_range(255)), 1'b1);
            end
            STRAY_CHAR: begin
                send_char(stray_char(), 1'b0);
            end
            FULL_ON_TERM: begin
                // the word fills the store exactly, so its terminator overflows
                send_char(word_char(1'b1), 1'b0);
                repeat (room - 1) begin
                    send_char(word_char(1'b0), 1'b0);
                end
                send_char(punct_char(), 1'b0);
            end
            default: begin
                send_char(CH_QUOTE, 1'b0);
                repeat (room + 1) begin
                    send_char(quoted_char(), 1'b0);
                end
            end
        endcase

        // halted: these beats must vanish without a token
        repeat (AFTER_HALT) begin
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        i_s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog: ends the run once no beat has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                    || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule
